### design/pidc_pkg.sv
// pidc_pkg: shared types and constants for the pid position controller
// used by pidc_serial_mult, pidc_serial_div and pid_position_controller
package pidc_pkg;

    localparam int FIELD_W   = 32;               // fixed width of every field and configuration register
    localparam int CFG_IDX_W = 2;                // four configuration registers

    // serial multiplier: 33-bit signed operands so unsigned dt fits as well
    localparam int MUL_W     = FIELD_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    // serial divider: |e - e_prev| * 2^16 over dt
    localparam int NUM_W     = FIELD_W + 1 + 16;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // wide signed width used for all sums before saturation
    localparam int WIDE_W    = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_KP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC_GO,
        ST_INC_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_P_GO,
        ST_P_WAIT,
        ST_I_GO,
        ST_I_WAIT,
        ST_D_GO,
        ST_D_WAIT,
        ST_FINISH
    } state_t;

endpackage

### design/pidc_serial_mult.sv
// pidc_serial_mult: bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on pidc_pkg
module pidc_serial_mult
    import pidc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic                     done,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] mcand_reg;
    logic        [MUL_W-1:0]  mplier_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // the top multiplier bit carries negative weight, so it subtracts
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= {{(PROD_W - MUL_W){op_a[MUL_W-1]}}, op_a};
            mplier_reg <= op_b;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                if (cnt_reg == MUL_CNT_W'(MUL_W - 1)) begin
                    acc_reg <= acc_reg - mcand_reg;
                end else begin
                    acc_reg <= acc_reg + mcand_reg;
                end
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### design/pidc_serial_div.sv
// pidc_serial_div: restoring unsigned divider, one quotient bit per cycle
// depends on pidc_pkg
module pidc_serial_div
    import pidc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   numerator,
    input  logic [FIELD_W-1:0] denominator,
    output logic               done,
    output logic [NUM_W-1:0]   quotient
);

    logic [NUM_W-1:0]     num_reg;   // numerator bits out at the top, quotient bits in at the bottom
    logic [FIELD_W-1:0]   den_reg;
    logic [FIELD_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [FIELD_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numerator;
            den_reg <= denominator;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= FIELD_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[FIELD_W-1:0];
            end
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### design/pid_position_controller.sv
// pid_position_controller: Q16.16 PID position controller, top level
// depends on pidc_pkg, pidc_serial_mult and pidc_serial_div
//
// An initialise item (mode 1) loads the previous error with the setpoint, clears the
// integral and gives no result. A compute item (mode 0) gives one result, and the next
// item is taken only after that result has gone to the output register: four products
// through one bit-serial multiplier (e*dt, kp*e, ki*integral, kd*derivative) and the
// derivative quotient through a bit-serial divider, all one after the other, plus a
// step to start and one to hand the result over. A stalled output holds the hand-over
// step until the output register is free.
// A finished result waits in the output register while the next item is taken in.
// WORD_WIDTH sets the saturation range of every word, between 16 and 32 bits.
module pid_position_controller
    import pidc_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic signed [31:0]   s_target_angle,
    input  logic signed [31:0]   s_measured_angle,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_command,
    output logic signed [31:0]   m_error_value
);

    localparam int SAT_W = (WORD_WIDTH > 32) ? 32 : ((WORD_WIDTH < 16) ? 16 : WORD_WIDTH);
    localparam logic signed [WIDE_W-1:0] SAT_MAX = (52'sd1 <<< (SAT_W - 1)) - 52'sd1;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - 52'sd1;

    function automatic logic [31:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > SAT_MAX) begin
            r = SAT_MAX;
        end else if (v < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[31:0];
    endfunction

    state_t state_reg, state_next;

    logic signed [31:0]        kp_reg, ki_reg, kd_reg;
    logic        [31:0]        dt_reg;
    logic        [31:0]        dt_eff;
    logic signed [31:0]        prev_err_reg, integ_reg;
    logic signed [31:0]        err_reg, deriv_reg;
    logic signed [WIDE_W-1:0]  sum_reg;
    logic                      deriv_neg_reg;
    logic                      m_valid_reg;
    logic signed [31:0]        m_command_reg, m_error_reg;

    logic                      accept;
    logic                      out_free;
    logic                      mul_start, mul_done;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [WIDE_W-1:0]  prod_floor;
    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_num, quotient;
    logic signed [32:0]        err_diff, deriv_diff;
    logic        [32:0]        deriv_mag;
    logic signed [WIDE_W-1:0]  quo_signed;

    assign dt_eff   = (dt_reg == 32'd0) ? 32'd1 : dt_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            dt_reg <= 32'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KP:  kp_reg <= cfg_wdata;
                CFG_KI:  ki_reg <= cfg_wdata;
                CFG_KD:  kd_reg <= cfg_wdata;
                CFG_DT:  dt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = {err_reg[31], err_reg};
        mul_b      = {1'b0, dt_eff};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !s_mode) begin
                    state_next = ST_INC_GO;
                end
            end
            ST_INC_GO: begin
                mul_start  = 1'b1;
                state_next = ST_INC_WAIT;
            end
            ST_INC_WAIT: begin
                if (mul_done) begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_P_GO;
                end
            end
            ST_P_GO: begin
                mul_b      = {kp_reg[31], kp_reg};
                mul_start  = 1'b1;
                state_next = ST_P_WAIT;
            end
            ST_P_WAIT: begin
                if (mul_done) begin
                    state_next = ST_I_GO;
                end
            end
            ST_I_GO: begin
                mul_a      = {integ_reg[31], integ_reg};
                mul_b      = {ki_reg[31], ki_reg};
                mul_start  = 1'b1;
                state_next = ST_I_WAIT;
            end
            ST_I_WAIT: begin
                if (mul_done) begin
                    state_next = ST_D_GO;
                end
            end
            ST_D_GO: begin
                mul_a      = {deriv_reg[31], deriv_reg};
                mul_b      = {kd_reg[31], kd_reg};
                mul_start  = 1'b1;
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT: begin
                if (mul_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    pidc_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (product)
    );

    pidc_serial_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (dt_eff),
        .done        (div_done),
        .quotient    (quotient)
    );

    // floor of product / 2^16 is an arithmetic shift
    assign prod_floor = {{(WIDE_W - (PROD_W - 16)){product[PROD_W-1]}}, product[PROD_W-1:16]};

    assign err_diff   = {s_target_angle[31], s_target_angle}
                      - {s_measured_angle[31], s_measured_angle};
    assign deriv_diff = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
    assign deriv_mag  = deriv_diff[32] ? 33'(-deriv_diff) : deriv_diff;
    assign div_num    = {deriv_mag, 16'd0};
    // quotient truncated toward zero: divide magnitudes, then restore the sign
    assign quo_signed = deriv_neg_reg ? -$signed({3'b000, quotient})
                                      :  $signed({3'b000, quotient});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else begin
            if (state_reg == ST_IDLE && accept && s_mode) begin
                prev_err_reg <= sat_word({{(WIDE_W - 32){s_target_angle[31]}}, s_target_angle});
                integ_reg    <= '0;
            end
            if (state_reg == ST_INC_WAIT && mul_done) begin
                integ_reg <= sat_word({{(WIDE_W - 32){integ_reg[31]}}, integ_reg} + prod_floor);
            end
            if (state_reg == ST_FINISH && out_free) begin
                prev_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_mode) begin
            err_reg <= sat_word({{(WIDE_W - 33){err_diff[32]}}, err_diff});
        end
        if (state_reg == ST_DIV_GO) begin
            deriv_neg_reg <= deriv_diff[32];
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            deriv_reg <= sat_word(quo_signed);
            sum_reg   <= '0;
        end
        if ((state_reg == ST_P_WAIT || state_reg == ST_I_WAIT || state_reg == ST_D_WAIT)
                && mul_done) begin
            sum_reg <= sum_reg + prod_floor;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_command_reg <= sat_word(sum_reg);
            m_error_reg   <= err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_command     = m_command_reg;
    assign m_error_value = m_error_reg;

endmodule

### tb/pidc_checker.sv
`timescale 1ns / 1ps
// pidc_checker: watches the pid position controller ports, predicts each command
// from its own copy of the gains and loop state, and compares results in order
// depends on pidc_pkg for the register index constants and field widths
module pidc_checker
    import pidc_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_mode,
    input  logic signed [31:0]   s_target_angle,
    input  logic signed [31:0]   s_measured_angle,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [31:0]   m_command,
    input  logic signed [31:0]   m_error_value,
    output int                   mismatch_count,
    output int                   drives_pending,
    output int                   drives_checked
);

    typedef struct packed {
        logic signed [31:0] command;
        logic signed [31:0] error_value;
    } drive_t;

    // the word range never leaves 16 to 32 bits
    localparam int SAT_BITS = (WORD_WIDTH > 32) ? 32 : ((WORD_WIDTH < 16) ? 16 : WORD_WIDTH);
    localparam longint WORD_MAX = (longint'(1) <<< (SAT_BITS - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [31:0]        period;
    logic signed [31:0] last_error;
    logic signed [31:0] integral_acc;
    drive_t             drive_q[$];

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // works out the next drive and advances the loop state
    function automatic drive_t predict_drive(longint target, longint measured);
        longint dt;
        longint err;
        longint integ;
        longint deriv;
        longint cmd;
        drive_t d;
        dt = (period == 0) ? 1 : period;
        err = clamp_word(target - measured);
        // arithmetic shift floors, signed divide truncates toward zero
        integ = clamp_word(longint'(integral_acc) + ((err * dt) >>> 16));
        deriv = clamp_word(((err - longint'(last_error)) * 65536) / dt);
        cmd = ((longint'(gain_p) * err) >>> 16)
            + ((longint'(gain_i) * integ) >>> 16)
            + ((longint'(gain_d) * deriv) >>> 16);
        cmd = clamp_word(cmd);
        last_error = err[31:0];
        integral_acc = integ[31:0];
        d.command = cmd[31:0];
        d.error_value = err[31:0];
        return d;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        drive_t want;
        if (!aresetn) begin
            gain_p = 0;
            gain_i = 0;
            gain_d = 0;
            period = 32'h0001_0000;
            last_error = 0;
            integral_acc = 0;
            drive_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KP: gain_p = cfg_wdata;
                    CFG_KI: gain_i = cfg_wdata;
                    CFG_KD: gain_d = cfg_wdata;
                    CFG_DT: period = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_mode) begin
                    last_error = 32'(clamp_word(s_target_angle));
                    integral_acc = 0;
                end else begin
                    drive_q.push_back(predict_drive(s_target_angle, s_measured_angle));
                end
            end
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected result, command", m_command, 0);
                end else begin
                    want = drive_q.pop_front();
                    if (m_command !== want.command)
                        report_mismatch("command", m_command, want.command);
                    if (m_error_value !== want.error_value)
                        report_mismatch("error_value", m_error_value, want.error_value);
                    drives_checked++;
                end
            end
        end
        drives_pending = drive_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for pid_position_controller, directed corners then
// random gain settings and angle streams; depends on pidc_pkg and pidc_checker
module tb_top;
    import pidc_pkg::*;

    localparam int WORD_BITS      = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] ANGLE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ANGLE_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam bit MODE_COMPUTE = 1'b0;
    localparam bit MODE_INIT    = 1'b1;

    logic                 aclk;
    logic                 aresetn          = 1'b0;
    logic                 cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = CFG_KP;
    logic [FIELD_W-1:0]   cfg_wdata        = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_mode           = MODE_COMPUTE;
    logic signed [31:0]   s_target_angle   = '0;
    logic signed [31:0]   s_measured_angle = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b1;
    logic signed [31:0]   m_command;
    logic signed [31:0]   m_error_value;

    int mismatch_count;
    int drives_pending;
    int drives_checked;

    bit quiet_sender;
    bit quiet_receiver;
    int items_sent;
    int inits_sent;
    int gain_settings;
    int idle_cycles;

    pid_position_controller #(.WORD_WIDTH(WORD_BITS)) dut (.*);

    pidc_checker #(.WORD_WIDTH(WORD_BITS)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4))
            0: return $urandom();
            1: return ($urandom_range(3) == 0) ? ANGLE_MAX
                    : ($urandom_range(1) ? ANGLE_MIN : Q_ONE);
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom();
            default: return $urandom_range(Q_ONE, 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(7))
            0, 1: return $urandom();
            2: return $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] dt);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_DT, dt);
        gain_settings++;
    endtask

    // leaves valid high after acceptance; the next call or stop_sending settles it
    task automatic send_item(bit mode, logic [31:0] target, logic [31:0] measured);
        int gap;
        gap = pick_gap(quiet_sender);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_target_angle <= target;
        s_measured_angle <= measured;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (mode == MODE_INIT) inits_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // an initialise item gives no result, so wait on past the last result for it to finish
    task automatic wait_drained();
        wait (drives_pending == 0);
        repeat (8) @(negedge aclk);
    endtask

    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(quiet_receiver);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pid_position_controller verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset gains are zero, so only the error comes through
        send_item(MODE_COMPUTE, ANGLE_MAX, ANGLE_MIN);
        send_item(MODE_INIT, 32'h1234_5678, 32'hFFFF_FFFF);
        stop_sending();
        wait_drained();

        set_gains(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE);
        send_item(MODE_INIT, 32'd0, 32'd0);
        send_item(MODE_COMPUTE, ANGLE_MAX, ANGLE_MIN);
        send_item(MODE_COMPUTE, ANGLE_MIN, ANGLE_MAX);
        send_item(MODE_COMPUTE, 32'd0, 32'd0);
        send_item(MODE_COMPUTE, 32'h0001_8000, 32'h0000_8000);
        send_item(MODE_COMPUTE, 32'hFFFF_FFFF, 32'd1);
        send_item(MODE_INIT, ANGLE_MAX, 32'd0);
        send_item(MODE_COMPUTE, 32'd0, 32'd0);
        send_item(MODE_INIT, ANGLE_MIN, 32'd0);
        send_item(MODE_COMPUTE, 32'd5, 32'd5);
        stop_sending();
        wait_drained();

        // zero period counts as the smallest one; the derivative runs into its limit
        set_gains(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 32'd0);
        repeat (3) send_item(MODE_COMPUTE, ANGLE_MAX, ANGLE_MIN);
        send_item(MODE_COMPUTE, ANGLE_MIN, ANGLE_MAX);
        send_item(MODE_COMPUTE, 32'd1, 32'd0);
        stop_sending();
        wait_drained();

        set_gains(ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, 32'hFFFF_FFFF);
        send_item(MODE_INIT, 32'd0, 32'd0);
        send_item(MODE_COMPUTE, ANGLE_MAX, ANGLE_MIN);
        send_item(MODE_COMPUTE, ANGLE_MIN, ANGLE_MAX);
        send_item(MODE_COMPUTE, 32'd1, 32'd0);
        send_item(MODE_COMPUTE, ANGLE_MIN, 32'd0);
        stop_sending();
        wait_drained();

        // random part: each phase a fresh set of gains, mostly with a loop started from a setpoint
        for (int phase = 0; phase < 8; phase++) begin
            quiet_sender = ($urandom_range(3) == 0);
            quiet_receiver = ($urandom_range(3) == 0);
            set_gains(pick_gain(), pick_gain(), pick_gain(), pick_period());
            if ($urandom_range(4) != 0) send_item(MODE_INIT, pick_angle(), $urandom());
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(99) < 8)
                    send_item(MODE_INIT, pick_angle(), $urandom());
                else
                    send_item(MODE_COMPUTE, pick_angle(), pick_angle());
            end
            stop_sending();
            wait_drained();
        end

        $display("run covered %0d items, %0d of them initialise, over %0d gain settings",
                 items_sent, inits_sent, gain_settings);
        $display("%0d commands compared, %0d mismatches", drives_checked, mismatch_count);
        if (mismatch_count == 0 && drives_pending == 0) begin
            $display("pid_position_controller verification clean");
        end else begin
            $display("pid_position_controller verification failed");
        end
        $finish;
    end

endmodule
